@@ sv/prq_pkg.sv @@
`default_nettype none

package prq_pkg;

    // Request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // Result status codes
    localparam int          STATUS_BITS  = 2;
    localparam logic [1:0]  STATUS_DONE  = 2'd0;
    localparam logic [1:0]  STATUS_FULL  = 2'd1;
    localparam logic [1:0]  STATUS_EMPTY = 2'd2;

    // Parameter defaults
    localparam int QUEUE_DEPTH_DEF   = 64;
    localparam int TAG_BITS_DEF      = 8;
    localparam int PRIORITY_BITS_DEF = 8;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic do_insert;
        logic do_remove;
    } t_prq_ctrl;

endpackage

`default_nettype wire

@@ sv/prq_cell.sv @@
`default_nettype none

module prq_cell #(
    parameter int TAG_BITS      = prq_pkg::TAG_BITS_DEF,
    parameter int PRIORITY_BITS = prq_pkg::PRIORITY_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire prq_pkg::t_prq_ctrl      i_ctrl,
    input  wire logic [TAG_BITS-1:0]     i_new_tag,
    input  wire logic [PRIORITY_BITS-1:0] i_new_prio,
    input  wire logic                    i_occupied,
    input  wire logic                    i_at_tail,
    input  wire logic                    i_left_lt,
    input  wire logic [TAG_BITS-1:0]     i_left_tag,
    input  wire logic [PRIORITY_BITS-1:0] i_left_prio,
    input  wire logic [TAG_BITS-1:0]     i_right_tag,
    input  wire logic [PRIORITY_BITS-1:0] i_right_prio,
    output logic                         o_lt,
    output logic [TAG_BITS-1:0]          o_tag,
    output logic [PRIORITY_BITS-1:0]     o_prio
);

    logic [TAG_BITS-1:0]      r_tag;
    logic [PRIORITY_BITS-1:0] r_prio;
    logic [TAG_BITS-1:0]      n_tag;
    logic [PRIORITY_BITS-1:0] n_prio;
    logic                     w_move;

    // Entry of strictly lower priority than the new one: it moves back
    assign o_lt   = i_occupied && (r_prio < i_new_prio);
    assign w_move = o_lt || i_at_tail;

    always_comb begin
        n_tag  = r_tag;
        n_prio = r_prio;
        if (i_ctrl.do_insert && w_move) begin
            if (i_left_lt) begin
                n_tag  = i_left_tag;
                n_prio = i_left_prio;
            end else begin
                n_tag  = i_new_tag;
                n_prio = i_new_prio;
            end
        end else if (i_ctrl.do_remove) begin
            n_tag  = i_right_tag;
            n_prio = i_right_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag  <= n_tag;
        r_prio <= n_prio;
    end

    assign o_tag  = r_tag;
    assign o_prio = r_prio;

endmodule

`default_nettype wire

@@ sv/priority_ready_queue_unit.sv @@
`default_nettype none

// Priority ready queue: process tags kept sorted by descending priority.
// Command channel: drive start with req_type, process_tag and priority_req;
// the item is taken at a rising edge with start high and busy low. busy is
// always low, so one item may be taken every cycle.
// An insert lands behind every entry of equal or higher priority (FIFO within
// one priority); into a full queue it is dropped with status FULL. A remove
// returns the head entry, or status EMPTY with zero tag and priority.
// Result channel: o_done pulses for one cycle, in the cycle after the item is
// taken, with status, removed tag/priority and the occupancy after the item.
// Throughput is one item per cycle. The rate is set by the row of QUEUE_DEPTH
// cells: every cell compares its priority with the new one and loads from its
// left neighbor, its right neighbor or the new item in the same cycle, so the
// whole row shifts at once.
// The receiver cannot stall; each result is valid in its strobe cycle only.
// Reset clears the occupancy count and the result strobe; cell contents stay
// undefined, and only cells below the count are ever read.
module priority_ready_queue_unit #(
    parameter int QUEUE_DEPTH   = prq_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS      = prq_pkg::TAG_BITS_DEF,
    parameter int PRIORITY_BITS = prq_pkg::PRIORITY_BITS_DEF,
    parameter int CNT_BITS      = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         i_req_type,
    input  wire logic [TAG_BITS-1:0]          i_process_tag,
    input  wire logic [PRIORITY_BITS-1:0]     i_priority_req,
    output logic                              o_done,
    output logic [prq_pkg::STATUS_BITS-1:0]   o_status,
    output logic [TAG_BITS-1:0]               o_removed_tag,
    output logic [PRIORITY_BITS-1:0]          o_removed_priority,
    output logic [CNT_BITS-1:0]               o_occupancy
);

    localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(QUEUE_DEPTH);

    logic                    w_accept;
    logic                    w_full;
    logic                    w_empty;
    prq_pkg::t_prq_ctrl      w_ctrl;

    logic [TAG_BITS-1:0]      w_tag  [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] w_prio [QUEUE_DEPTH];
    logic                     w_lt   [QUEUE_DEPTH];

    logic [CNT_BITS-1:0]              r_count, n_count;
    logic                             r_done;
    logic [prq_pkg::STATUS_BITS-1:0]  r_status, n_status;
    logic [TAG_BITS-1:0]              r_rtag, n_rtag;
    logic [PRIORITY_BITS-1:0]         r_rprio, n_rprio;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = (r_count == DEPTH_CNT);
    assign w_empty  = (r_count == '0);

    // Broadcast command: drop inserts into a full queue, removes from empty
    assign w_ctrl.do_insert = w_accept && (i_req_type == prq_pkg::REQ_INSERT) && !w_full;
    assign w_ctrl.do_remove = w_accept && (i_req_type == prq_pkg::REQ_REMOVE) && !w_empty;

    // Row of cells, head at index 0
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic                     w_left_lt;
        logic [TAG_BITS-1:0]      w_left_tag, w_right_tag;
        logic [PRIORITY_BITS-1:0] w_left_prio, w_right_prio;

        if (g == 0) begin : g_head
            assign w_left_lt   = 1'b0;
            assign w_left_tag  = i_process_tag;
            assign w_left_prio = i_priority_req;
        end else begin : g_mid
            assign w_left_lt   = w_lt[g-1];
            assign w_left_tag  = w_tag[g-1];
            assign w_left_prio = w_prio[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            // Last cell holds on remove
            assign w_right_tag  = w_tag[g];
            assign w_right_prio = w_prio[g];
        end else begin : g_body
            assign w_right_tag  = w_tag[g+1];
            assign w_right_prio = w_prio[g+1];
        end

        prq_cell #(
            .TAG_BITS      (TAG_BITS),
            .PRIORITY_BITS (PRIORITY_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_new_tag    (i_process_tag),
            .i_new_prio   (i_priority_req),
            .i_occupied   (CNT_BITS'(g) < r_count),
            .i_at_tail    (CNT_BITS'(g) == r_count),
            .i_left_lt    (w_left_lt),
            .i_left_tag   (w_left_tag),
            .i_left_prio  (w_left_prio),
            .i_right_tag  (w_right_tag),
            .i_right_prio (w_right_prio),
            .o_lt         (w_lt[g]),
            .o_tag        (w_tag[g]),
            .o_prio       (w_prio[g])
        );
    end

    // Count and result for the item taken this cycle
    always_comb begin
        n_count  = r_count;
        n_status = prq_pkg::STATUS_DONE;
        n_rtag   = '0;
        n_rprio  = '0;
        if (i_req_type == prq_pkg::REQ_INSERT) begin
            if (w_full) begin
                n_status = prq_pkg::STATUS_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (w_empty) begin
                n_status = prq_pkg::STATUS_EMPTY;
            end else begin
                n_count = r_count - 1'b1;
                n_rtag  = w_tag[0];
                n_rprio = w_prio[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    // Result payload: hold until the next item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_rtag   <= n_rtag;
            r_rprio  <= n_rprio;
        end
    end

    assign o_done             = r_done;
    assign o_status           = r_status;
    assign o_removed_tag      = r_rtag;
    assign o_removed_priority = r_rprio;
    assign o_occupancy        = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_CNT)
        else $error("occupancy above queue depth");

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_done)
        else $error("accepted item produced no result strobe");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == prq_pkg::STATUS_FULL) |-> (o_occupancy == DEPTH_CNT))
        else $error("full status with queue not full");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == prq_pkg::STATUS_EMPTY)
            |-> (o_occupancy == '0 && o_removed_tag == '0 && o_removed_priority == '0))
        else $error("empty status with nonzero payload");

endmodule

`default_nettype wire

@@ sim/prq_checker.sv @@
`timescale 1ns / 100ps

module prq_checker (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_start,
    input  wire logic                                   i_busy,
    input  wire logic                                   i_req_type,
    input  wire logic [prq_pkg::TAG_BITS_DEF-1:0]       i_process_tag,
    input  wire logic [prq_pkg::PRIORITY_BITS_DEF-1:0]  i_priority_req,
    input  wire logic                                   i_done,
    input  wire logic [prq_pkg::STATUS_BITS-1:0]        i_status,
    input  wire logic [prq_pkg::TAG_BITS_DEF-1:0]       i_removed_tag,
    input  wire logic [prq_pkg::PRIORITY_BITS_DEF-1:0]  i_removed_priority,
    input  wire logic [$clog2(prq_pkg::QUEUE_DEPTH_DEF+1)-1:0] i_occupancy,
    output int                                          o_fail_count,
    output int                                          o_pending
);
    import prq_pkg::*;

    localparam int DEPTH  = QUEUE_DEPTH_DEF;
    localparam int TAG_W  = TAG_BITS_DEF;
    localparam int PRIO_W = PRIORITY_BITS_DEF;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH_DEF + 1);

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [TAG_W-1:0]       tag;
        logic [PRIO_W-1:0]      prio;
        logic [CNT_W-1:0]       occupancy;
    } queue_reply_t;

    // Shadow of the sorted queue, head at slot 0
    logic [TAG_W-1:0]  shadow_tag  [DEPTH];
    logic [PRIO_W-1:0] shadow_prio [DEPTH];
    int                shadow_count;

    queue_reply_t      queued_replies [$];

    function automatic queue_reply_t predict_queue_reply(
        input logic             req,
        input logic [TAG_W-1:0] tag,
        input logic [PRIO_W-1:0] prio
    );
        queue_reply_t reply;
        int           pos;
        reply = '0;
        reply.status = STATUS_DONE;
        if (req == REQ_INSERT) begin
            if (shadow_count >= DEPTH) begin
                reply.status = STATUS_FULL;
            end else begin
                // slide strictly lower priorities back, keep FIFO among equals
                pos = shadow_count;
                while (pos > 0 && shadow_prio[pos-1] < prio) begin
                    shadow_tag[pos]  = shadow_tag[pos-1];
                    shadow_prio[pos] = shadow_prio[pos-1];
                    pos--;
                end
                shadow_tag[pos]  = tag;
                shadow_prio[pos] = prio;
                shadow_count++;
            end
        end else begin
            if (shadow_count == 0) begin
                reply.status = STATUS_EMPTY;
            end else begin
                reply.tag  = shadow_tag[0];
                reply.prio = shadow_prio[0];
                for (int i = 1; i < shadow_count; i++) begin
                    shadow_tag[i-1]  = shadow_tag[i];
                    shadow_prio[i-1] = shadow_prio[i];
                end
                shadow_count--;
            end
        end
        reply.occupancy = CNT_W'(shadow_count);
        return reply;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        shadow_count = 0;
    end

    always @(posedge i_clk) begin
        queue_reply_t want;
        queue_reply_t got;
        if (!i_rst_n) begin
            shadow_count = 0;
            queued_replies.delete();
        end else begin
            // check the result first: it belongs to an item taken earlier
            if (i_done) begin
                got = {i_status, i_removed_tag, i_removed_priority, i_occupancy};
                if (queued_replies.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: result with nothing pending: status=%0d tag=%0d prio=%0d occ=%0d",
                                 $realtime, got.status, got.tag, got.prio, got.occupancy);
                end else begin
                    want = queued_replies.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: mismatch exp status=%0d tag=%0d prio=%0d occ=%0d, act status=%0d tag=%0d prio=%0d occ=%0d",
                                     $realtime, want.status, want.tag, want.prio,
                                     want.occupancy, got.status, got.tag, got.prio,
                                     got.occupancy);
                    end
                end
            end
            if (i_start && !i_busy)
                queued_replies.push_back(
                    predict_queue_reply(i_req_type, i_process_tag, i_priority_req));
        end
        o_pending = queued_replies.size();
    end

endmodule

@@ sim/priority_ready_queue_unit_tb.sv @@
`timescale 1ns / 100ps

module priority_ready_queue_unit_tb;
    import prq_pkg::*;

    localparam int DEPTH       = QUEUE_DEPTH_DEF;
    localparam int TAG_W       = TAG_BITS_DEF;
    localparam int PRIO_W      = PRIORITY_BITS_DEF;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH_DEF + 1);
    localparam int RANDOM_ITEMS = 600;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 8;

    // Priority spread used inside one random phase
    typedef enum int { PRIO_FULL_RANGE, PRIO_FEW_LEVELS, PRIO_EXTREMES } prio_mode_t;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               start          = 1'b0;
    logic               i_req_type     = REQ_INSERT;
    logic [TAG_W-1:0]   i_process_tag  = '0;
    logic [PRIO_W-1:0]  i_priority_req = '0;
    logic               busy;
    logic               o_done;
    logic [STATUS_BITS-1:0] o_status;
    logic [TAG_W-1:0]   o_removed_tag;
    logic [PRIO_W-1:0]  o_removed_priority;
    logic [CNT_W-1:0]   o_occupancy;

    int                 fail_count;
    int                 pending;
    int                 cycle_count = 0;
    bit                 gaps_on     = 1'b1;

    always #5 i_clk = ~i_clk;

    priority_ready_queue_unit u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_req_type         (i_req_type),
        .i_process_tag      (i_process_tag),
        .i_priority_req     (i_priority_req),
        .o_done             (o_done),
        .o_status           (o_status),
        .o_removed_tag      (o_removed_tag),
        .o_removed_priority (o_removed_priority),
        .o_occupancy        (o_occupancy)
    );

    // Checker watches both channels and keeps the failure tally
    prq_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .i_busy             (busy),
        .i_req_type         (i_req_type),
        .i_process_tag      (i_process_tag),
        .i_priority_req     (i_priority_req),
        .i_done             (o_done),
        .i_status           (o_status),
        .i_removed_tag      (o_removed_tag),
        .i_removed_priority (o_removed_priority),
        .i_occupancy        (o_occupancy),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    // Watchdog: end the run if the block stops taking items or answering
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Present one item and hold it until the block takes it.
    // Sometimes drop start first so gaps land between items.
    task automatic send_item(
        input logic              req,
        input logic [TAG_W-1:0]  tag,
        input logic [PRIO_W-1:0] prio
    );
        int idle_len;
        if (gaps_on && $urandom_range(0, 99) < 12) begin
            idle_len = $urandom_range(1, 3);
            start <= 1'b0;
            // scramble the idle bus; the block must ignore it
            i_req_type     <= 1'($urandom);
            i_process_tag  <= TAG_W'($urandom);
            i_priority_req <= PRIO_W'($urandom);
            repeat (idle_len) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_req_type     <= req;
        i_process_tag  <= tag;
        i_priority_req <= prio;
        // advance until start is seen high with busy low
        do @(posedge i_clk); while (busy);
    endtask

    function automatic logic [PRIO_W-1:0] pick_priority(input prio_mode_t mode);
        case (mode)
            PRIO_FEW_LEVELS: return PRIO_W'($urandom_range(0, 3));
            PRIO_EXTREMES:   return $urandom_range(0, 1) ? '1 : '0;
            default:         return PRIO_W'($urandom);
        endcase
    endfunction

    // Random payload for a remove: the fields are ignored but still toggle
    task automatic send_remove();
        send_item(REQ_REMOVE, TAG_W'($urandom), PRIO_W'($urandom));
    endtask

    initial begin
        int         sent;
        int         phase_len;
        int         insert_pct;
        prio_mode_t mode;

        // hold reset, then release
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: remove from an empty queue
        send_remove();
        // field extremes on insert
        send_item(REQ_INSERT, 8'h00, 8'h00);
        send_item(REQ_INSERT, 8'hFF, 8'hFF);
        send_item(REQ_INSERT, 8'hAA, 8'h55);
        send_item(REQ_INSERT, 8'h55, 8'hAA);
        // equal priorities must leave in arrival order
        send_item(REQ_INSERT, 8'h01, 8'h80);
        send_item(REQ_INSERT, 8'h02, 8'h80);
        send_item(REQ_INSERT, 8'h03, 8'h80);
        send_item(REQ_INSERT, 8'h04, 8'hFF);
        send_item(REQ_INSERT, 8'h05, 8'h00);
        // drain everything, then three more removes on empty
        repeat (10) send_remove();
        send_item(REQ_REMOVE, 8'h00, 8'h00);
        send_item(REQ_REMOVE, 8'hFF, 8'hFF);

        // Random part. Fill past full first so drops are exercised, then
        // drain past empty, then wander between phases of varying bias.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent == 0) begin
                phase_len  = DEPTH + 10;
                insert_pct = 100;
                mode       = PRIO_FEW_LEVELS;
            end else if (sent == DEPTH + 10) begin
                phase_len  = DEPTH + 6;
                insert_pct = 0;
                mode       = PRIO_FULL_RANGE;
            end else begin
                phase_len = $urandom_range(20, 110);
                case ($urandom_range(0, 2))
                    0:       insert_pct = 88;
                    1:       insert_pct = 12;
                    default: insert_pct = 50;
                endcase
                mode = prio_mode_t'($urandom_range(0, 2));
            end
            repeat (phase_len) begin
                // keep one long stretch free of gaps
                gaps_on = !(sent >= 250 && sent < 400);
                if ($urandom_range(0, 99) < insert_pct)
                    send_item(REQ_INSERT, TAG_W'($urandom), pick_priority(mode));
                else
                    send_remove();
                sent++;
            end
        end
        start <= 1'b0;

        // wait for every outstanding result, then idle before the verdict
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/prq_pkg.sv
sv/prq_cell.sv
sv/priority_ready_queue_unit.sv
sim/prq_checker.sv
sim/priority_ready_queue_unit_tb.sv
